[rtl/dap_pkg.sv]
// Shared types, widths and constants for the dihedral angle pipeline.
// No dependencies; every other rtl file refers to this package by scope.
package dap_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
  localparam int RED_WIDTH    = 31;            // reduced component, [-2^30, 2^30)
  localparam int FIT_BITS     = 30;
  localparam int PROD_WIDTH   = 2 * RED_WIDTH;
  localparam int WIDE_WIDTH   = 64;
  localparam int SHIFT_WIDTH  = 6;
  localparam int SQ_STEPS     = 32;            // one result bit per stage
  localparam int ROOT_WIDTH   = 32;
  localparam int CORDIC_STEPS = 25;
  localparam int CX_WIDTH     = 34;            // CORDIC x/y incl. gain growth
  localparam int Z_WIDTH      = 30;            // angle accumulator, Q20 degrees
  localparam int TORSION_WIDTH = 25;
  localparam int IN_TDATA_WIDTH  = ((12 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_WIDTH = ((TORSION_WIDTH + 7) / 8) * 8;

  localparam logic signed [Z_WIDTH-1:0] DEG90_Q20  = Z_WIDTH'(90 <<< 20);
  localparam logic signed [Z_WIDTH-1:0] DEG180_Q20 = Z_WIDTH'(180 <<< 20);
  localparam logic signed [Z_WIDTH-1:0] ROUND_Q20  = Z_WIDTH'(8);

  // atan(2^-i) in degrees, Q20
  localparam logic signed [Z_WIDTH-1:0] ATAN_Q20 [CORDIC_STEPS] = '{
    30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121, 30'sd3750058,
    30'sd1876857,  30'sd938658,   30'sd469357,   30'sd234682,  30'sd117342,
    30'sd58671,    30'sd29335,    30'sd14668,    30'sd7334,    30'sd3667,
    30'sd1833,     30'sd917,      30'sd458,      30'sd229,     30'sd115,
    30'sd57,       30'sd29,       30'sd14,       30'sd7,       30'sd4
  };

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // sideband that rides along the root extraction
  typedef struct packed {
    logic                           degen;
    logic                           spos;
    logic [SHIFT_WIDTH-1:0]         kc;
    logic signed [WIDE_WIDTH-1:0]   x;
  } dap_side_t;

  // flags that ride along the CORDIC stages
  typedef struct packed {
    logic degen;
    logic spos;
    logic yzero;
    logic xneg;
  } dap_flag_t;

  // Halvings needed so all three values land in [-2^30, 2^30).
  function automatic logic [SHIFT_WIDTH-1:0] fit_shift3(
    input logic signed [WIDE_WIDTH-1:0] a,
    input logic signed [WIDE_WIDTH-1:0] b,
    input logic signed [WIDE_WIDTH-1:0] c
  );
    logic [WIDE_WIDTH-1:0] m;
    logic [SHIFT_WIDTH:0]  len;
    m = (a ^ {WIDE_WIDTH{a[WIDE_WIDTH-1]}}) | (b ^ {WIDE_WIDTH{b[WIDE_WIDTH-1]}}) |
        (c ^ {WIDE_WIDTH{c[WIDE_WIDTH-1]}});
    len = '0;
    for (int i = 0; i < WIDE_WIDTH; i++) begin
      if (m[i]) len = (SHIFT_WIDTH+1)'(i + 1);
    end
    return (len > (SHIFT_WIDTH+1)'(FIT_BITS)) ?
           SHIFT_WIDTH'(len - (SHIFT_WIDTH+1)'(FIT_BITS)) : '0;
  endfunction

endpackage

[rtl/dihedral_angle_four_points.sv]
// Top level of the dihedral (torsion) angle pipeline with its output skid.
// Depends on dap_pkg, dap_vec, dap_isqrt and dap_cordic.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tdata: 12 coords a.x .. d.z, 32b each
//  out_    | out | out_tvalid/out_tready| tdata: torsion_degrees; tuser: degenerate
//
// One request is taken every cycle while in_tready is high; results come out in
// order through 13 vector stages, 32 root stages, 29 angle stages and then the
// output register; the root extraction is the largest share of that path.
// rst_n is synchronous, active low, and clears all valid bits and the skid.
// When out_tready drops, the skid register catches the one item in flight and
// in_tready falls the cycle after; the whole pipeline then holds until drained.
module dihedral_angle_four_points (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // a.x, a.y, a.z, b.x, b.y, b.z, c.x, c.y, c.z, d.x, d.y, d.z (low bits first)
  input  logic [dap_pkg::IN_TDATA_WIDTH-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // torsion_degrees [24:0], zero fill above
  output logic [dap_pkg::OUT_TDATA_WIDTH-1:0]    out_tdata,
  // degenerate [0]
  output logic                                   out_tuser
);

  localparam int CW = dap_pkg::COORD_WIDTH;
  localparam int TW = dap_pkg::TORSION_WIDTH;

  dap_pkg::coord_t      pt [12];
  logic                 adv;
  logic                 vec_vld, sq_vld, cor_vld;
  dap_pkg::dap_side_t   vec_side, sq_side;
  logic [dap_pkg::WIDE_WIDTH-1:0] vec_ss;
  logic [dap_pkg::ROOT_WIDTH-1:0] sq_root;
  logic signed [TW-1:0] cor_tors;
  logic                 cor_degen;

  // output register and skid
  logic                 out_vld_r, skid_vld_r;
  logic signed [TW-1:0] out_tors_r, skid_tors_r;
  logic                 out_dg_r, skid_dg_r;

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      pt[i] = in_tdata[i*CW +: CW];
    end
  end

  // pipeline moves whenever the skid is free
  assign adv       = !skid_vld_r;
  assign in_tready = adv;

  dap_vec u_vec (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (in_tvalid),
    .pt      (pt),
    .out_vld (vec_vld),
    .side    (vec_side),
    .ss      (vec_ss)
  );

  dap_isqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (vec_vld),
    .ss       (vec_ss),
    .side_in  (vec_side),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .side_out (sq_side)
  );

  dap_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (sq_vld),
    .root    (sq_root),
    .side    (sq_side),
    .out_vld (cor_vld),
    .torsion (cor_tors),
    .degen   (cor_degen)
  );

  // An item leaves the last stage only when adv is high. If the output
  // register is busy and stalled it parks in the skid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_tready) begin
        skid_vld_r <= 1'b0;
      end
    end else if (cor_vld) begin
      if (!out_vld_r || out_tready) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_tready) begin
        out_tors_r <= skid_tors_r;
        out_dg_r   <= skid_dg_r;
      end
    end else if (cor_vld) begin
      if (!out_vld_r || out_tready) begin
        out_tors_r <= cor_tors;
        out_dg_r   <= cor_degen;
      end else begin
        skid_tors_r <= cor_tors;
        skid_dg_r   <= cor_degen;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(dap_pkg::OUT_TDATA_WIDTH-TW){1'b0}}, out_tors_r};
  assign out_tuser  = out_dg_r;

endmodule

[rtl/dap_vec.sv]
// Vector front end: bond vectors, plane normals, dot and cross of normals.
// Depends on dap_pkg. Thirteen register stages, one item per cycle while en is high.
module dap_vec (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  dap_pkg::coord_t                   pt [12],
  output logic                              out_vld,
  output dap_pkg::dap_side_t                side,
  output logic [dap_pkg::WIDE_WIDTH-1:0]    ss
);

  localparam int STAGES = 13;
  localparam int DW = dap_pkg::DIFF_WIDTH;
  localparam int RW = dap_pkg::RED_WIDTH;
  localparam int PW = dap_pkg::PROD_WIDTH;
  localparam int WW = dap_pkg::WIDE_WIDTH;
  localparam int SW = dap_pkg::SHIFT_WIDTH;

  logic [STAGES-1:0] v_r;

  // S1 differences
  logic signed [DW-1:0] b_r [9];
  // S2 shift amounts
  logic signed [DW-1:0] bd_r [9];
  logic [SW-1:0]        bk_r [3];
  // S3 reduced bond vectors
  logic signed [RW-1:0] br_r [9];
  // S4 products
  logic signed [PW-1:0] p_r [12];
  logic signed [RW-1:0] b2a_r [3];
  // S5 normals
  logic signed [WW-1:0] n_nxt [6];
  logic signed [WW-1:0] n_r [6];
  logic signed [RW-1:0] b2b_r [3];
  logic                 dg5_r;
  // S6
  logic signed [WW-1:0] nd_r [6];
  logic [SW-1:0]        nk_r [2];
  logic signed [RW-1:0] b2c_r [3];
  logic                 dg6_r;
  // S7
  logic signed [RW-1:0] nr_r [6];
  logic signed [RW-1:0] b2d_r [3];
  logic                 dg7_r;
  // S8
  logic signed [PW-1:0] q_r [9];
  logic signed [RW-1:0] b2e_r [3];
  logic                 dg8_r;
  // S9
  logic signed [WW-1:0] x9_r;
  logic signed [WW-1:0] c_r [3];
  logic signed [RW-1:0] b2f_r [3];
  logic                 dg9_r;
  // S10
  logic signed [WW-1:0] x10_r;
  logic signed [WW-1:0] cd_r [3];
  logic [SW-1:0]        kc10_r;
  logic signed [RW-1:0] b2g_r [3];
  logic                 dg10_r;
  // S11
  logic signed [WW-1:0] x11_r;
  logic signed [RW-1:0] cr_r [3];
  logic [SW-1:0]        kc11_r;
  logic signed [RW-1:0] b2h_r [3];
  logic                 dg11_r;
  // S12
  logic signed [WW-1:0] x12_r;
  logic signed [PW-1:0] sq_r [3];
  logic signed [PW-1:0] sp_r [3];
  logic [SW-1:0]        kc12_r;
  logic                 dg12_r;
  // S13
  logic signed [WW-1:0] s_nxt;
  logic [WW-1:0]        ss_r;
  dap_pkg::dap_side_t   side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STAGES-2:0], in_vld};
    end
  end

  always_comb begin
    for (int e = 0; e < 6; e++) begin
      n_nxt[e] = WW'(p_r[2*e]) - WW'(p_r[2*e+1]);
    end
    s_nxt = WW'(sp_r[0]) + WW'(sp_r[1]) + WW'(sp_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // S1: b1 = a - b, b2 = b - c, b3 = d - c
      for (int i = 0; i < 3; i++) begin
        b_r[i]   <= DW'(pt[i])   - DW'(pt[3+i]);
        b_r[3+i] <= DW'(pt[3+i]) - DW'(pt[6+i]);
        b_r[6+i] <= DW'(pt[9+i]) - DW'(pt[6+i]);
      end
      // S2
      bd_r <= b_r;
      for (int v = 0; v < 3; v++) begin
        bk_r[v] <= dap_pkg::fit_shift3(WW'(b_r[3*v]), WW'(b_r[3*v+1]), WW'(b_r[3*v+2]));
      end
      // S3
      for (int v = 0; v < 3; v++) begin
        for (int e = 0; e < 3; e++) begin
          br_r[3*v+e] <= RW'(bd_r[3*v+e] >>> bk_r[v]);
        end
      end
      // S4: n1 = b1 x b2, n2 = b3 x b2
      p_r[0]  <= br_r[1] * br_r[5];
      p_r[1]  <= br_r[2] * br_r[4];
      p_r[2]  <= br_r[2] * br_r[3];
      p_r[3]  <= br_r[0] * br_r[5];
      p_r[4]  <= br_r[0] * br_r[4];
      p_r[5]  <= br_r[1] * br_r[3];
      p_r[6]  <= br_r[7] * br_r[5];
      p_r[7]  <= br_r[8] * br_r[4];
      p_r[8]  <= br_r[8] * br_r[3];
      p_r[9]  <= br_r[6] * br_r[5];
      p_r[10] <= br_r[6] * br_r[4];
      p_r[11] <= br_r[7] * br_r[3];
      b2a_r   <= br_r[3:5];
      // S5
      n_r   <= n_nxt;
      dg5_r <= (n_nxt[0] == '0 && n_nxt[1] == '0 && n_nxt[2] == '0) ||
               (n_nxt[3] == '0 && n_nxt[4] == '0 && n_nxt[5] == '0);
      b2b_r <= b2a_r;
      // S6
      nd_r    <= n_r;
      nk_r[0] <= dap_pkg::fit_shift3(n_r[0], n_r[1], n_r[2]);
      nk_r[1] <= dap_pkg::fit_shift3(n_r[3], n_r[4], n_r[5]);
      b2c_r   <= b2b_r;
      dg6_r   <= dg5_r;
      // S7
      for (int e = 0; e < 3; e++) begin
        nr_r[e]   <= RW'(nd_r[e]   >>> nk_r[0]);
        nr_r[3+e] <= RW'(nd_r[3+e] >>> nk_r[1]);
      end
      b2d_r <= b2c_r;
      dg7_r <= dg6_r;
      // S8: n1 . n2 and n1 x n2
      q_r[0] <= nr_r[0] * nr_r[3];
      q_r[1] <= nr_r[1] * nr_r[4];
      q_r[2] <= nr_r[2] * nr_r[5];
      q_r[3] <= nr_r[1] * nr_r[5];
      q_r[4] <= nr_r[2] * nr_r[4];
      q_r[5] <= nr_r[2] * nr_r[3];
      q_r[6] <= nr_r[0] * nr_r[5];
      q_r[7] <= nr_r[0] * nr_r[4];
      q_r[8] <= nr_r[1] * nr_r[3];
      b2e_r  <= b2d_r;
      dg8_r  <= dg7_r;
      // S9
      x9_r   <= WW'(q_r[0]) + WW'(q_r[1]) + WW'(q_r[2]);
      c_r[0] <= WW'(q_r[3]) - WW'(q_r[4]);
      c_r[1] <= WW'(q_r[5]) - WW'(q_r[6]);
      c_r[2] <= WW'(q_r[7]) - WW'(q_r[8]);
      b2f_r  <= b2e_r;
      dg9_r  <= dg8_r;
      // S10
      x10_r  <= x9_r;
      cd_r   <= c_r;
      kc10_r <= dap_pkg::fit_shift3(c_r[0], c_r[1], c_r[2]);
      b2g_r  <= b2f_r;
      dg10_r <= dg9_r;
      // S11
      x11_r <= x10_r;
      for (int e = 0; e < 3; e++) begin
        cr_r[e] <= RW'(cd_r[e] >>> kc10_r);
      end
      kc11_r <= kc10_r;
      b2h_r  <= b2g_r;
      dg11_r <= dg10_r;
      // S12: squares for |c|, and c . b2 for the sign
      x12_r <= x11_r;
      for (int e = 0; e < 3; e++) begin
        sq_r[e] <= cr_r[e] * cr_r[e];
        sp_r[e] <= cr_r[e] * b2h_r[e];
      end
      kc12_r <= kc11_r;
      dg12_r <= dg11_r;
      // S13
      ss_r         <= WW'(sq_r[0]) + WW'(sq_r[1]) + WW'(sq_r[2]);
      side_r.degen <= dg12_r;
      side_r.spos  <= (s_nxt > 0);
      side_r.kc    <= kc12_r;
      side_r.x     <= x12_r;
    end
  end

  assign out_vld = v_r[STAGES-1];
  assign side    = side_r;
  assign ss      = ss_r;

endmodule

[rtl/dap_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on dap_pkg. Carries the item's sideband alongside.
module dap_isqrt (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic [dap_pkg::WIDE_WIDTH-1:0]     ss,
  input  dap_pkg::dap_side_t                 side_in,
  output logic                               out_vld,
  output logic [dap_pkg::ROOT_WIDTH-1:0]     root,
  output dap_pkg::dap_side_t                 side_out
);

  localparam int N  = dap_pkg::SQ_STEPS;
  localparam int WW = dap_pkg::WIDE_WIDTH;

  logic [N-1:0]       v_r;
  logic [WW-1:0]      n_r [N];
  logic [WW-1:0]      r_r [N];
  dap_pkg::dap_side_t s_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], in_vld};
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam logic [WW-1:0] BIT = WW'(1) << (2 * (N - 1 - j));
    logic [WW-1:0]      n_in;
    logic [WW-1:0]      r_in;
    logic [WW-1:0]      trial;
    logic [WW-1:0]      n_nxt;
    logic [WW-1:0]      r_nxt;
    dap_pkg::dap_side_t s_in;

    if (j == 0) begin : g_first
      assign n_in = ss;
      assign r_in = '0;
      assign s_in = side_in;
    end else begin : g_next
      assign n_in = n_r[j-1];
      assign r_in = r_r[j-1];
      assign s_in = s_r[j-1];
    end

    always_comb begin
      trial = r_in + BIT;
      if (n_in >= trial) begin
        n_nxt = n_in - trial;
        r_nxt = (r_in >> 1) + BIT;
      end else begin
        n_nxt = n_in;
        r_nxt = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[j] <= n_nxt;
        r_r[j] <= r_nxt;
        s_r[j] <= s_in;
      end
    end
  end

  assign out_vld  = v_r[N-1];
  assign root     = r_r[N-1][dap_pkg::ROOT_WIDTH-1:0];
  assign side_out = s_r[N-1];

endmodule

[rtl/dap_cordic.sv]
// Angle stage: scales (x, y), folds to the right half plane, runs the
// CORDIC vectoring steps and forms the signed result. Depends on dap_pkg.
module dap_cordic (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     en,
  input  logic                                     in_vld,
  input  logic [dap_pkg::ROOT_WIDTH-1:0]           root,
  input  dap_pkg::dap_side_t                       side,
  output logic                                     out_vld,
  output logic signed [dap_pkg::TORSION_WIDTH-1:0] torsion,
  output logic                                     degen
);

  localparam int N      = dap_pkg::CORDIC_STEPS;
  localparam int STAGES = N + 4;
  localparam int WW     = dap_pkg::WIDE_WIDTH;
  localparam int RW     = dap_pkg::RED_WIDTH;
  localparam int XW     = dap_pkg::CX_WIDTH;
  localparam int ZW     = dap_pkg::Z_WIDTH;
  localparam int SW     = dap_pkg::SHIFT_WIDTH;
  localparam int TW     = dap_pkg::TORSION_WIDTH;

  logic [STAGES-1:0] v_r;

  // C1: y = root << kc
  logic signed [WW-1:0] x1_r, y1_r;
  logic [1:0]           f1_r;        // {degen, spos}
  // C2: joint shift amount
  logic signed [WW-1:0] x2_r, y2_r;
  logic [SW-1:0]        k2_r;
  logic [1:0]           f2_r;
  // C3: scaled and folded start vector
  logic signed [RW-1:0] xs, ys;
  logic signed [XW-1:0] x_r [N+1];
  logic signed [XW-1:0] y_r [N+1];
  logic signed [ZW-1:0] z_r [N+1];
  dap_pkg::dap_flag_t   f_r [N+1];
  // final
  logic signed [ZW-1:0] zc;
  logic signed [ZW-1:0] zr;
  logic signed [TW-1:0] t_nxt;
  logic signed [TW-1:0] t_r;
  logic                 dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STAGES-2:0], in_vld};
    end
  end

  always_comb begin
    xs = RW'(x2_r >>> k2_r);
    ys = RW'(y2_r >>> k2_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= side.x;
      y1_r <= WW'(root) << side.kc;
      f1_r <= {side.degen, side.spos};
      x2_r <= x1_r;
      y2_r <= y1_r;
      k2_r <= dap_pkg::fit_shift3(x1_r, y1_r, y1_r);
      f2_r <= f1_r;
      // left half plane: rotate by -90 degrees first
      if (xs[RW-1]) begin
        x_r[0] <= XW'(ys);
        y_r[0] <= -XW'(xs);
        z_r[0] <= dap_pkg::DEG90_Q20;
      end else begin
        x_r[0] <= XW'(xs);
        y_r[0] <= XW'(ys);
        z_r[0] <= '0;
      end
      f_r[0].degen <= f2_r[1];
      f_r[0].spos  <= f2_r[0];
      f_r[0].yzero <= (ys == '0);
      f_r[0].xneg  <= xs[RW-1];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [XW-1:0] dx, dy;
    assign dx = x_r[i] >>> i;
    assign dy = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[i][XW-1]) begin
          x_r[i+1] <= x_r[i] + dy;
          y_r[i+1] <= y_r[i] - dx;
          z_r[i+1] <= z_r[i] + dap_pkg::ATAN_Q20[i];
        end else begin
          x_r[i+1] <= x_r[i] - dy;
          y_r[i+1] <= y_r[i] + dx;
          z_r[i+1] <= z_r[i] - dap_pkg::ATAN_Q20[i];
        end
        f_r[i+1] <= f_r[i];
      end
    end
  end

  always_comb begin
    if (f_r[N].yzero) begin
      zc = f_r[N].xneg ? dap_pkg::DEG180_Q20 : '0;
    end else if (z_r[N][ZW-1]) begin
      zc = '0;
    end else if (z_r[N] > dap_pkg::DEG180_Q20) begin
      zc = dap_pkg::DEG180_Q20;
    end else begin
      zc = z_r[N];
    end
    zr = (zc + dap_pkg::ROUND_Q20) >>> 4;
    if (f_r[N].degen) begin
      t_nxt = '0;
    end else if (f_r[N].spos) begin
      t_nxt = -TW'(zr);
    end else begin
      t_nxt = TW'(zr);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r  <= t_nxt;
      dg_r <= f_r[N].degen;
    end
  end

  assign out_vld = v_r[STAGES-1];
  assign torsion = t_r;
  assign degen   = dg_r;

endmodule

[rtl/dap_checker.sv]
// Port-level checks on the dihedral angle block, bound to the top level.
// Depends on dap_pkg and the dihedral_angle_four_points port names.
module dap_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [dap_pkg::OUT_TDATA_WIDTH-1:0] out_tdata,
  input logic                                out_tuser
);

  // nothing comes out right after a reset
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // back-pressure on input only while a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // a full skid stays full until the output side takes something
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && !out_tready |=> !in_tready)
    else $error("input stall released without output progress");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind dihedral_angle_four_points dap_checker u_dap_checker (.*);
